[hdl/tcce_pkg.sv]
// Package for the text console character engine.
// Holds geometry constants, character and request codes, channel payload structs,
// and the controller command/status types. No dependencies.
package tcce_pkg;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELL_COUNT   = COLUMNS * ROWS;
    localparam int SCROLL_COUNT = COLUMNS * (ROWS - 1);

    localparam int ADDR_W       = $clog2(CELL_COUNT);
    localparam int COL_W        = $clog2(COLUMNS);
    localparam int ROW_W        = $clog2(ROWS + 1);

    localparam int CELL_W       = 16;
    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int TAB_W        = 7;
    localparam int REQ_W        = 2;
    localparam int CELL_INDEX_W = 11;
    localparam int OFFSET_W     = 11;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [ADDR_W-1:0]       COLUMNS_A   = ADDR_W'(COLUMNS);
    localparam logic [7:0]              COLUMNS_C8  = 8'(COLUMNS);
    localparam logic [ROW_W-1:0]        ROWS_R      = ROW_W'(ROWS);
    localparam logic [ROW_W-1:0]        ROW_LAST    = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0]       SCROLL_LAST = ADDR_W'(SCROLL_COUNT - 1);
    localparam logic [ADDR_W-1:0]       CELL_LAST   = ADDR_W'(CELL_COUNT - 1);
    localparam logic [CELL_INDEX_W:0]   CELL_LIMIT  = (CELL_INDEX_W + 1)'(CELL_COUNT);

    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h1F;
    localparam logic [TAB_W-1:0]  TAB_RESET   = 7'd8;
    localparam logic [CELL_W-1:0] BLANK_RESET = {ATTR_RESET, CHAR_SPACE};

    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_ATTR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAB_WIDTH = 2'd1;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [CHAR_W-1:0]       char_code;
        logic [CELL_INDEX_W-1:0] cell_index;
    } tcce_in_t;

    typedef struct packed {
        logic [CELL_W-1:0]   cell_value;
        logic [OFFSET_W-1:0] cursor_offset;
        logic                did_scroll;
    } tcce_out_t;

    typedef enum logic [3:0] {
        ST_INIT_FILL,
        ST_IDLE,
        ST_DECODE,
        ST_READ_WAIT,
        ST_SCROLL_COPY,
        ST_SCROLL_DRAIN,
        ST_SCROLL_FILL,
        ST_CLEAR_FILL,
        ST_RESPOND
    } tcce_state_t;

    typedef struct packed {
        logic req_load;
        logic cursor_update;
        logic read_issue;
        logic copy_step;
        logic fill_step;
        logic fill_reset_blank;
        logic sweep_clr;
        logic out_load;
    } tcce_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             needs_scroll;
        logic             copy_last;
        logic             fill_last;
        logic             out_free;
    } tcce_status_t;

endpackage

[hdl/tcce_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Used for the console cell store. No package dependencies.
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/tcce_ctrl.sv]
// Controller state machine for the text console character engine.
// Sequences requests, store sweeps and result hand-off; depends on tcce_pkg.
module tcce_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tcce_pkg::tcce_status_t status,
    output tcce_pkg::tcce_cmd_t    cmd
);
    import tcce_pkg::*;

    tcce_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT_FILL;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT_FILL: begin
                if (status.fill_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                case (status.req_type)
                    REQ_PUT: begin
                        if (status.needs_scroll) state_next = ST_SCROLL_COPY;
                        else if (status.out_free) state_next = ST_IDLE;
                    end
                    REQ_READ:  state_next = ST_READ_WAIT;
                    REQ_CLEAR: state_next = ST_CLEAR_FILL;
                    default: begin
                        if (status.out_free) state_next = ST_IDLE;
                    end
                endcase
            end
            ST_READ_WAIT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            ST_SCROLL_COPY: begin
                if (status.copy_last) state_next = ST_SCROLL_DRAIN;
            end
            ST_SCROLL_DRAIN: state_next = ST_SCROLL_FILL;
            ST_SCROLL_FILL: begin
                if (status.fill_last) state_next = ST_RESPOND;
            end
            ST_CLEAR_FILL: begin
                if (status.fill_last) state_next = ST_RESPOND;
            end
            ST_RESPOND: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_INIT_FILL: begin
                cmd.fill_step        = 1'b1;
                cmd.fill_reset_blank = 1'b1;
            end
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.req_load = s_valid;
            end
            ST_DECODE: begin
                case (status.req_type)
                    REQ_PUT: begin
                        if (status.needs_scroll) begin
                            cmd.cursor_update = 1'b1;
                            cmd.sweep_clr     = 1'b1;
                        end else if (status.out_free) begin
                            cmd.cursor_update = 1'b1;
                            cmd.out_load      = 1'b1;
                        end
                    end
                    REQ_READ:  cmd.read_issue = 1'b1;
                    REQ_CLEAR: cmd.sweep_clr  = 1'b1;
                    default:   cmd.out_load   = status.out_free;
                endcase
            end
            ST_READ_WAIT:    cmd.out_load  = status.out_free;
            ST_SCROLL_COPY:  cmd.copy_step = 1'b1;
            ST_SCROLL_DRAIN: cmd = '0;
            ST_SCROLL_FILL:  cmd.fill_step = 1'b1;
            ST_CLEAR_FILL:   cmd.fill_step = 1'b1;
            ST_RESPOND:      cmd.out_load  = status.out_free;
            default:         cmd = '0;
        endcase
    end

endmodule

[hdl/tcce_datapath.sv]
// Datapath for the text console character engine: cursor, configuration,
// sweep counter, cell store and result register. Depends on tcce_pkg and tcce_ram.
module tcce_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tcce_pkg::tcce_cmd_t                  cmd,
    output tcce_pkg::tcce_status_t               status,
    input  tcce_pkg::tcce_in_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tcce_pkg::tcce_out_t                  m_data,
    input  logic                                cfg_valid,
    input  logic [tcce_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tcce_pkg::*;

    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic [TAB_W-1:0]  tab_reg, tab_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    tcce_in_t          req_reg, req_next;
    logic              in_range_reg, in_range_next;
    logic              scroll_reg, scroll_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0] wr_pend_addr_reg, wr_pend_addr_next;
    logic              m_valid_reg, m_valid_next;
    tcce_out_t         m_data_reg, m_data_next;

    logic [7:0]        col8, w8, tab_mask, tab_col, put_col;
    logic              lf, wrap, printable, needs_scroll, out_free;
    logic [ROW_W-1:0]  row_raw, row_new, row_view;
    logic [COL_W-1:0]  col_new, col_view;
    logic [ADDR_W-1:0] cur_addr, ofs_full;
    logic [CELL_W-1:0] fill_value;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    tcce_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELL_COUNT)
    ) u_cells (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        col8     = 8'(col_reg);
        w8       = 8'(tab_reg);
        tab_mask = ~(w8 - 8'd1);
        tab_col  = (col8 + w8) & tab_mask;
        lf       = 1'b0;
        put_col  = col8;
        printable = req_reg.char_code >= CHAR_SPACE;
        case (req_reg.char_code)
            CHAR_TAB: put_col = tab_col;
            CHAR_CR:  put_col = 8'd0;
            CHAR_LF: begin
                put_col = 8'd0;
                lf      = 1'b1;
            end
            CHAR_BS:  put_col = (col8 == 8'd0) ? col8 : col8 - 8'd1;
            default: begin
                if (printable) put_col = col8 + 8'd1;
            end
        endcase
        wrap         = put_col >= COLUMNS_C8;
        row_raw      = row_reg + ROW_W'(lf || wrap);
        needs_scroll = row_raw == ROWS_R;
        col_new      = wrap ? '0 : COL_W'(put_col);
        row_new      = needs_scroll ? ROW_LAST : row_raw;
    end

    assign col_view   = cmd.cursor_update ? col_new : col_reg;
    assign row_view   = cmd.cursor_update ? row_new : row_reg;
    assign cur_addr   = ADDR_W'(row_reg) * COLUMNS_A + ADDR_W'(col_reg);
    assign ofs_full   = ADDR_W'(row_view) * COLUMNS_A + ADDR_W'(col_view);
    assign fill_value = cmd.fill_reset_blank ? BLANK_RESET : {attr_reg, CHAR_SPACE};
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = {attr_reg, req_reg.char_code};
        if (wr_pend_reg) begin
            ram_we    = 1'b1;
            ram_waddr = wr_pend_addr_reg;
            ram_wdata = ram_rdata;
        end else if (cmd.fill_step) begin
            ram_we    = 1'b1;
            ram_waddr = sweep_reg;
            ram_wdata = fill_value;
        end else if (cmd.cursor_update && printable) begin
            ram_we    = 1'b1;
        end
        ram_re    = cmd.read_issue || cmd.copy_step;
        ram_raddr = cmd.copy_step ? sweep_reg + COLUMNS_A : ADDR_W'(req_reg.cell_index);
    end

    always_comb begin
        attr_next = attr_reg;
        tab_next  = tab_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_TEXT_ATTR: attr_next = cfg_data;
                CFG_TAB_WIDTH: tab_next  = TAB_W'(cfg_data);
                default: ;
            endcase
        end

        col_next = cmd.cursor_update ? col_new : col_reg;
        row_next = cmd.cursor_update ? row_new : row_reg;

        req_next      = cmd.req_load ? s_data : req_reg;
        in_range_next = cmd.req_load ? ({1'b0, s_data.cell_index} < CELL_LIMIT) : in_range_reg;

        scroll_next = scroll_reg;
        if (cmd.req_load) scroll_next = 1'b0;
        else if (cmd.cursor_update && needs_scroll) scroll_next = 1'b1;

        sweep_next = sweep_reg;
        if (cmd.sweep_clr) sweep_next = '0;
        else if (cmd.copy_step || cmd.fill_step) sweep_next = sweep_reg + ADDR_W'(1);

        wr_pend_next      = cmd.copy_step;
        wr_pend_addr_next = sweep_reg;

        m_data_next = m_data_reg;
        if (cmd.out_load) begin
            m_data_next.cell_value    = (req_reg.req_type == REQ_READ && in_range_reg)
                                        ? ram_rdata : '0;
            m_data_next.cursor_offset = OFFSET_W'(ofs_full);
            m_data_next.did_scroll    = scroll_reg;
        end
        m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg    <= ATTR_RESET;
            tab_reg     <= TAB_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            scroll_reg  <= 1'b0;
            sweep_reg   <= '0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            attr_reg    <= attr_next;
            tab_reg     <= tab_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            scroll_reg  <= scroll_next;
            sweep_reg   <= sweep_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg          <= req_next;
        in_range_reg     <= in_range_next;
        wr_pend_addr_reg <= wr_pend_addr_next;
        m_data_reg       <= m_data_next;
    end

    assign status.req_type     = req_reg.req_type;
    assign status.needs_scroll = needs_scroll;
    assign status.copy_last    = sweep_reg == SCROLL_LAST;
    assign status.fill_last    = sweep_reg == CELL_LAST;
    assign status.out_free     = out_free;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hdl/text_console_character_engine_core.sv]
// Top level of the text console character engine: controller plus datapath.
// Depends on tcce_pkg, tcce_ctrl, tcce_datapath and tcce_ram.
//
//   Channel   Ports                                   Moves
//   input     s_valid, s_ready, s_data                one request per transfer
//   result    m_valid, m_ready, m_data                one result per request
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data   one register write
//
// A clear sweeps the whole cell store with blanks; a scroll adds a sweep that copies
// each row up one and then blanks the last row.
// After reset the store is swept to blanks before s_ready rises. A waiting result
// is held in the output register while the next request is taken; the block
// stalls only when it must place a new result there.
module text_console_character_engine_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tcce_pkg::tcce_in_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tcce_pkg::tcce_out_t              m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcce_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tcce_pkg::*;

    tcce_cmd_t    cmd;
    tcce_status_t status;

    assign cfg_ready = 1'b1;

    tcce_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .status (status),
        .cmd    (cmd)
    );

    tcce_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

endmodule

[hdl/tcce_checker.sv]
// Port-level checker for the text console character engine, with its bind.
// Depends on tcce_pkg and the top level text_console_character_engine_core.
module tcce_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input tcce_pkg::tcce_out_t m_data,
    input logic                m_valid,
    input logic                m_ready
);
    import tcce_pkg::*;

    // The store is swept after reset, so no request is taken right away.
    a_init_not_ready: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in progress");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    a_offset_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_data.cursor_offset} < CELL_LIMIT))
        else $error("cursor offset outside the screen");

    a_scroll_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.did_scroll |-> m_data.cell_value == '0)
        else $error("scroll result carries cell data");

endmodule

bind text_console_character_engine_core tcce_checker u_tcce_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_data (m_data),
    .m_valid(m_valid),
    .m_ready(m_ready)
);
